// ===== src/pre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and constants of the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

    localparam int MAX_MINIMUM = 64;
    localparam int RUN_LIMIT   = 4096;

    localparam int MIN_W   = 7;                       // min_length width
    localparam int IDX_W   = $clog2(MAX_MINIMUM);     // prefix store index
    localparam int COUNT_W = $clog2(RUN_LIMIT + 1);   // run count, holds RUN_LIMIT

    localparam logic [7:0]       PRINT_LOW    = 8'h20;
    localparam logic [7:0]       PRINT_HIGH   = 8'h7e;
    localparam logic [7:0]       NEWLINE_BYTE = 8'h0a;
    localparam logic [MIN_W-1:0] MIN_RESET    = MIN_W'(4);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_STORE,
        ACT_BYTE,
        ACT_NEWLINE,
        ACT_REPLAY
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_TAIL
    } t_state;

    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic rep_read;   // read prefix entry at replay index
        logic rep_emit;   // send read prefix byte, step index
        logic tail_emit;  // send the byte that completed the threshold
    } t_dp_cmd;

    typedef struct packed {
        t_action action;     // what the offered input item would do
        logic    slot_free;  // output register can take a new result
        logic    rep_last;   // current index is the last stored prefix byte
    } t_dp_status;

endpackage

// ===== src/printable_run_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printable_run_extractor
// Passes on printable ASCII runs of at least min_length bytes, each ended
// by a newline.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while no replay runs and the output register
// is free or being drained. When a run reaches the threshold m (m of 2 or
// more), the stored prefix is replayed from the 64-entry prefix store: each
// stored byte is first read from memory (S_READ), then sent (S_EMIT); S_TAIL
// then sends the byte that reached m. The input is held until that is done.
// min_length above 64 acts as 64; write it only while the block is idle.
module printable_run_extractor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pre_pkg::MIN_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  pre_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pre_pkg::t_out_item        o_out_data
);
    import pre_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    pre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pre_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/pre_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_ctrl
// Controller: input handshake and sequencing of the prefix replay.
// ----------------------------------------------------------------------------
module pre_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pre_pkg::t_dp_status i_status,
    output pre_pkg::t_dp_cmd    o_cmd
);
    import pre_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = i_status.slot_free;
                o_cmd.accept = i_in_valid && i_status.slot_free;
                if (o_cmd.accept && i_status.action == ACT_REPLAY) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rep_read = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.rep_emit = 1'b1;
                    n_state        = i_status.rep_last ? S_TAIL : S_READ;
                end
            end
            S_TAIL: begin
                if (i_status.slot_free) begin
                    o_cmd.tail_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pre_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_dp
// Datapath: threshold register, run counter, prefix store, output register.
// ----------------------------------------------------------------------------
module pre_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pre_pkg::MIN_W-1:0]      i_cfg_data,
    input  pre_pkg::t_in_item              i_in_data,
    input  pre_pkg::t_dp_cmd               i_cmd,
    output pre_pkg::t_dp_status            o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pre_pkg::t_out_item             o_out_data
);
    import pre_pkg::*;

    logic [MIN_W-1:0]   r_min_length;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [IDX_W-1:0]   r_idx;
    logic [7:0]         r_hold;
    logic [7:0]         r_rd_data;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic [7:0]         mem [MAX_MINIMUM];

    logic [MIN_W-1:0]   thresh;
    logic [COUNT_W-1:0] thresh_ext;
    logic [COUNT_W-1:0] count_inc;
    logic               printable;
    t_action            action;

    // threshold saturates at the prefix store depth
    assign thresh     = (r_min_length > MIN_W'(MAX_MINIMUM)) ? MIN_W'(MAX_MINIMUM)
                                                             : r_min_length;
    assign thresh_ext = COUNT_W'(thresh);
    assign count_inc  = r_count + COUNT_W'(1);
    assign printable  = !i_in_data.end_of_stream
                        && i_in_data.data_byte >= PRINT_LOW
                        && i_in_data.data_byte <= PRINT_HIGH;

    always_comb begin
        action  = ACT_NONE;
        n_count = r_count;
        if (printable) begin
            if (r_count < COUNT_W'(RUN_LIMIT)) begin
                n_count = count_inc;
                if (count_inc < thresh_ext) begin
                    action = ACT_STORE;
                end else if (count_inc == thresh_ext && thresh >= MIN_W'(2)) begin
                    action = ACT_REPLAY;
                end else begin
                    action = ACT_BYTE;
                end
            end
        end else begin
            n_count = '0;
            if (r_count >= thresh_ext) begin
                action = ACT_NEWLINE;
            end
        end
    end

    assign o_status.action    = action;
    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.rep_last  = {1'b0, r_idx} == (thresh - MIN_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_RESET;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_length <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_count <= n_count;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // prefix store, write while a run is below the threshold, registered read during replay
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && action == ACT_STORE) begin
            mem[r_count[IDX_W-1:0]] <= i_in_data.data_byte;
        end
        if (i_cmd.rep_read) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hold <= i_in_data.data_byte;
            r_idx  <= '0;
        end else if (i_cmd.rep_emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_out <= n_out;
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (i_cmd.accept && action == ACT_BYTE) begin
            n_out_valid = 1'b1;
            n_out       = '{out_byte: i_in_data.data_byte, last_of_run: 1'b1};
        end else if (i_cmd.accept && action == ACT_NEWLINE) begin
            n_out_valid = 1'b1;
            n_out       = '{out_byte: NEWLINE_BYTE, last_of_run: 1'b1};
        end else if (i_cmd.rep_emit) begin
            n_out_valid = 1'b1;
            n_out       = '{out_byte: r_rd_data, last_of_run: 1'b0};
        end else if (i_cmd.tail_emit) begin
            n_out_valid = 1'b1;
            n_out       = '{out_byte: r_hold, last_of_run: 1'b1};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
